### src/drawbridge_sequencer_core_macros.svh
// Assertion macros for the drawbridge sequencer checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef DRAWBRIDGE_SEQUENCER_CORE_MACROS_SVH
`define DRAWBRIDGE_SEQUENCER_CORE_MACROS_SVH

// Clocked property, switched off while reset is applied
`define DBS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge
`define DBS_NEVER(label, cond, msg) \
	`DBS_ASSERT(label, !(cond), msg)

`endif

### src/dbs_pkg.sv
// Shared types and constants of the drawbridge sequencer.
// No dependencies; used by every module of the block.
package dbs_pkg;

	localparam int unsigned PosW    = 16;
	localparam int unsigned StepW   = 10;
	localparam int unsigned TicksW  = 8;
	localparam int unsigned WaitW   = 12;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [PosW-1:0]   OpenPosReset   = 16'd2999;
	localparam logic [PosW-1:0]   ClosedPosReset = 16'd949;
	localparam logic [StepW-1:0]  StepSizeReset  = 10'd10;
	localparam logic [TicksW-1:0] StepTicksReset = 8'd5;
	localparam logic [WaitW-1:0]  WarnWaitReset  = 12'd1500;
	localparam logic [WaitW-1:0]  SettleReset    = 12'd50;

	// register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] REG_OPEN_POS   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_CLOSED_POS = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_STEP_SIZE  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_STEP_TICKS = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_WARN_WAIT  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SETTLE     = 3'd5;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_CONFIRM1 = 4'd1,
		PH_WARN     = 4'd2,
		PH_CLOSE    = 4'd3,
		PH_RAISE    = 4'd4,
		PH_FAR_LOW  = 4'd5,
		PH_SETTLE   = 4'd6,
		PH_FAR_HIGH = 4'd7,
		PH_CONFIRM2 = 4'd8,
		PH_LOWER    = 4'd9,
		PH_OPEN     = 4'd10,
		PH_END      = 4'd11
	} phase_t;

	typedef struct packed {
		logic [PosW-1:0]   open_pos;
		logic [PosW-1:0]   closed_pos;
		logic [StepW-1:0]  step_size;
		logic [TicksW-1:0] step_ticks;
		logic [WaitW-1:0]  warn_wait;
		logic [WaitW-1:0]  settle;
	} cfg_t;

	typedef struct packed {
		phase_t           phase;
		logic             far_is_b;
		logic [WaitW-1:0] wait_count;
		logic [PosW-1:0]  servo;
		logic             motor_up;
		logic             motor_down;
		logic             frozen;
		logic             last_emerg;
	} seq_state_t;

	typedef struct packed {
		logic sensor_a;
		logic sensor_b;
		logic limit_lower;
		logic limit_upper;
		logic confirm_button;
		logic resume_button;
		logic emergency_pin;
	} tick_t;

	typedef struct packed {
		logic            motor_raise;
		logic            motor_lower;
		logic            confirm_lamp;
		logic            boat_green;
		logic            boat_red;
		logic [PosW-1:0] barrier_position;
		logic            barrier_drive;
		logic            warning_blink;
		logic            halted;
	} result_t;

endpackage

### src/dbs_cfg.sv
// Configuration register file of the drawbridge sequencer.
// Depends on dbs_pkg for register indexes, widths and reset values.
module dbs_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [dbs_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [dbs_pkg::PosW-1:0]     cfg_data,
	output dbs_pkg::cfg_t                cfg
);
	import dbs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_pos   <= OpenPosReset;
			cfg_q.closed_pos <= ClosedPosReset;
			cfg_q.step_size  <= StepSizeReset;
			cfg_q.step_ticks <= StepTicksReset;
			cfg_q.warn_wait  <= WarnWaitReset;
			cfg_q.settle     <= SettleReset;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_OPEN_POS:   cfg_q.open_pos   <= cfg_data;
				REG_CLOSED_POS: cfg_q.closed_pos <= cfg_data;
				REG_STEP_SIZE:  cfg_q.step_size  <= cfg_data[StepW-1:0];
				REG_STEP_TICKS: cfg_q.step_ticks <= cfg_data[TicksW-1:0];
				REG_WARN_WAIT:  cfg_q.warn_wait  <= cfg_data[WaitW-1:0];
				REG_SETTLE:     cfg_q.settle     <= cfg_data[WaitW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/dbs_step.sv
// One-tick update of the sequencer: next phase, timers, ramp and result item.
// Depends on dbs_pkg; purely combinational.
module dbs_step (
	input  dbs_pkg::cfg_t       cfg,
	input  dbs_pkg::seq_state_t cur,
	input  dbs_pkg::tick_t      tick,
	output dbs_pkg::seq_state_t nxt,
	output dbs_pkg::result_t    result
);
	import dbs_pkg::*;

	logic              far_level;
	logic              wait_end;
	logic [WaitW-1:0]  wait_dec;
	logic [StepW-1:0]  step;
	logic [PosW:0]     close_floor;
	logic              close_more;
	logic [PosW:0]     open_next;
	logic              open_more;
	logic              edge_seen;
	logic              green;

	always_comb begin
		far_level   = cur.far_is_b ? tick.sensor_b : tick.sensor_a;
		wait_end    = (cur.wait_count <= WaitW'(1));
		wait_dec    = cur.wait_count - WaitW'(1);
		step        = (cfg.step_size == '0) ? StepW'(1) : cfg.step_size;
		close_floor = {1'b0, cfg.closed_pos} + (PosW+1)'(step);
		close_more  = ({1'b0, cur.servo} >= close_floor);
		open_next   = {1'b0, cur.servo} + (PosW+1)'(step);
		open_more   = (open_next <= {1'b0, cfg.open_pos});
		edge_seen   = (tick.emergency_pin != cur.last_emerg);
	end

	always_comb begin
		nxt = cur;
		nxt.last_emerg = tick.emergency_pin;
		if (cur.frozen) begin
			if (!tick.resume_button)
				nxt.frozen = 1'b0;
		end else if (edge_seen) begin
			nxt.motor_up   = 1'b0;
			nxt.motor_down = 1'b0;
			nxt.frozen     = 1'b1;
		end else begin
			case (cur.phase)
				PH_CONFIRM1: begin
					if (!tick.confirm_button) begin
						nxt.wait_count = cfg.warn_wait;
						nxt.phase      = PH_WARN;
					end
				end
				PH_WARN: begin
					if (wait_end) begin
						nxt.wait_count = '0;
						if (cfg.open_pos >= cfg.closed_pos) begin
							nxt.servo      = cfg.open_pos;
							nxt.wait_count = WaitW'(cfg.step_ticks);
							nxt.phase      = PH_CLOSE;
						end else begin
							nxt.phase = PH_RAISE;
						end
					end else begin
						nxt.wait_count = wait_dec;
					end
				end
				PH_CLOSE: begin
					if (wait_end) begin
						nxt.wait_count = '0;
						if (close_more) begin
							nxt.servo      = cur.servo - PosW'(step);
							nxt.wait_count = WaitW'(cfg.step_ticks);
						end else begin
							nxt.phase = PH_RAISE;
						end
					end else begin
						nxt.wait_count = wait_dec;
					end
				end
				PH_RAISE: begin
					if (!tick.limit_upper) begin
						nxt.motor_up = 1'b0;
						nxt.phase    = PH_FAR_LOW;
					end else begin
						nxt.motor_up = 1'b1;
					end
				end
				PH_FAR_LOW: begin
					if (!far_level) begin
						nxt.wait_count = cfg.settle;
						nxt.phase      = PH_SETTLE;
					end
				end
				PH_SETTLE: begin
					if (wait_end) begin
						nxt.wait_count = '0;
						nxt.phase      = PH_FAR_HIGH;
					end else begin
						nxt.wait_count = wait_dec;
					end
				end
				PH_FAR_HIGH: begin
					if (far_level)
						nxt.phase = PH_CONFIRM2;
				end
				PH_CONFIRM2: begin
					if (!tick.confirm_button)
						nxt.phase = PH_LOWER;
				end
				PH_LOWER: begin
					if (!tick.limit_lower) begin
						nxt.motor_down = 1'b0;
						if (cfg.closed_pos <= cfg.open_pos) begin
							nxt.servo      = cfg.closed_pos;
							nxt.wait_count = WaitW'(cfg.step_ticks);
							nxt.phase      = PH_OPEN;
						end else begin
							nxt.wait_count = cfg.warn_wait;
							nxt.phase      = PH_END;
						end
					end else begin
						nxt.motor_down = 1'b1;
					end
				end
				PH_OPEN: begin
					if (wait_end) begin
						nxt.wait_count = '0;
						if (open_more) begin
							nxt.servo      = open_next[PosW-1:0];
							nxt.wait_count = WaitW'(cfg.step_ticks);
						end else begin
							nxt.wait_count = cfg.warn_wait;
							nxt.phase      = PH_END;
						end
					end else begin
						nxt.wait_count = wait_dec;
					end
				end
				PH_END: begin
					if (wait_end) begin
						nxt.wait_count = '0;
						nxt.phase      = PH_IDLE;
					end else begin
						nxt.wait_count = wait_dec;
					end
				end
				default: begin
					// sensor A has priority; the other sensor becomes the far one
					nxt.phase = PH_IDLE;
					if (!tick.sensor_a) begin
						nxt.far_is_b = 1'b1;
						nxt.phase    = PH_CONFIRM1;
					end else if (!tick.sensor_b) begin
						nxt.far_is_b = 1'b0;
						nxt.phase    = PH_CONFIRM1;
					end
				end
			endcase
		end
	end

	always_comb begin
		green                   = (nxt.phase >= PH_FAR_LOW) && (nxt.phase <= PH_CONFIRM2);
		result.motor_raise      = nxt.motor_up;
		result.motor_lower      = nxt.motor_down;
		result.confirm_lamp     = (nxt.phase == PH_CONFIRM1) || (nxt.phase == PH_CONFIRM2);
		result.boat_green       = green;
		result.boat_red         = !green;
		result.barrier_position = nxt.servo;
		result.barrier_drive    = (nxt.phase == PH_CLOSE) || (nxt.phase == PH_OPEN);
		result.warning_blink    = (nxt.phase >= PH_WARN) && (nxt.phase <= PH_END);
		result.halted           = nxt.frozen;
	end

endmodule

### src/drawbridge_sequencer_core.sv
// Top level of the drawbridge sequencer: input stage, sequencer state, result stage.
// Depends on dbs_pkg, dbs_cfg and dbs_step.
//
//  channel   direction  handshake                 payload
//  tick      in         tick_valid / tick_stall   tick   (dbs_pkg::tick_t)
//  result    out        result_valid/result_stall result (dbs_pkg::result_t)
//  cfg       in         cfg_write                 cfg_index, cfg_data
//
// One tick per cycle sustained while result_stall is low; each tick is taken into the input
// register, then the state update writes its result into the result register.
// Reset puts the sequence in idle with the barrier at the open position and the state
// and configuration registers at their default values.
// A stalled result holds the input register, and tick_stall rises only then.
module drawbridge_sequencer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tick_valid,
	output logic                        tick_stall,
	input  dbs_pkg::tick_t              tick,
	output logic                        result_valid,
	input  logic                        result_stall,
	output dbs_pkg::result_t            result,
	input  logic                        cfg_write,
	input  logic [dbs_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [dbs_pkg::PosW-1:0]    cfg_data
);
	import dbs_pkg::*;

	cfg_t       cfg;
	seq_state_t state_q;
	seq_state_t state_nxt;
	result_t    result_nxt;
	tick_t      tick_s1;
	logic       valid_s1;
	logic       advance;
	result_t    result_s2;
	logic       valid_s2;

	dbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dbs_step u_step (
		.cfg    (cfg),
		.cur    (state_q),
		.tick   (tick_s1),
		.nxt    (state_nxt),
		.result (result_nxt)
	);

	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign tick_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!tick_stall)
			valid_s1 <= tick_valid;
	end

	always_ff @(posedge clk) begin
		if (!tick_stall && tick_valid)
			tick_s1 <= tick;
	end

	// commit the state only when the transaction moves into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_IDLE;
			state_q.far_is_b   <= 1'b0;
			state_q.wait_count <= '0;
			state_q.servo      <= OpenPosReset;
			state_q.motor_up   <= 1'b0;
			state_q.motor_down <= 1'b0;
			state_q.frozen     <= 1'b0;
			state_q.last_emerg <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (!result_stall)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= result_nxt;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

### src/dbs_checker.sv
// Port-level checker for the drawbridge sequencer, bound to the top level.
// Depends on dbs_pkg and drawbridge_sequencer_core_macros.svh.
`include "drawbridge_sequencer_core_macros.svh"

module dbs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        result_valid,
	input logic                        result_stall,
	input dbs_pkg::result_t            result
);

	// a stalled result transaction must hold
	`DBS_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "result changed while stalled")

	`DBS_NEVER(a_motor_both, result_valid && result.motor_raise && result.motor_lower, "deck motor driven both ways")

	`DBS_NEVER(a_lights, result_valid && (result.boat_red == result.boat_green), "boat lights not complementary")

	`DBS_NEVER(a_halt_motor, result_valid && result.halted && (result.motor_raise || result.motor_lower), "motor running while halted")

	`DBS_NEVER(a_ramp_blink, result_valid && result.barrier_drive && !result.warning_blink, "barrier ramp without warning blink")

endmodule

bind drawbridge_sequencer_core dbs_checker u_dbs_checker (.*);

### tb/sv/tb_drawbridge_sequencer_core.sv
// Self-checking testbench for drawbridge_sequencer_core: directed walk, then steered random ticks.
// Holds its own sequencer predictor in a scoreboard class; depends on dbs_pkg and the core RTL.
module tb_drawbridge_sequencer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dbs_pkg::*;

	localparam int unsigned WatchdogLimit = 1000;
	localparam int unsigned PipeLatency   = 8;

	class bridge_scoreboard;
		cfg_t             regs;
		phase_t           phase;
		logic             far_is_b;
		logic [WaitW-1:0] wait_count;
		logic [PosW-1:0]  servo;
		logic             motor_up;
		logic             motor_down;
		logic             frozen;
		logic             last_emerg;
		result_t          pending_outputs[$];
		int unsigned      errors;
		int unsigned      checked;

		function new();
			regs.open_pos   = OpenPosReset;
			regs.closed_pos = ClosedPosReset;
			regs.step_size  = StepSizeReset;
			regs.step_ticks = StepTicksReset;
			regs.warn_wait  = WarnWaitReset;
			regs.settle     = SettleReset;
			phase      = PH_IDLE;
			far_is_b   = 1'b0;
			wait_count = '0;
			servo      = OpenPosReset;
			motor_up   = 1'b0;
			motor_down = 1'b0;
			frozen     = 1'b0;
			last_emerg = 1'b0;
			errors     = 0;
			checked    = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [PosW-1:0] data);
			case (idx)
				REG_OPEN_POS:   regs.open_pos   = data;
				REG_CLOSED_POS: regs.closed_pos = data;
				REG_STEP_SIZE:  regs.step_size  = data[StepW-1:0];
				REG_STEP_TICKS: regs.step_ticks = data[TicksW-1:0];
				REG_WARN_WAIT:  regs.warn_wait  = data[WaitW-1:0];
				REG_SETTLE:     regs.settle     = data[WaitW-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_outputs.size();
		endfunction

		// count a running wait down; true once it has run out
		function bit wait_over();
			if (wait_count > 1) begin
				wait_count = wait_count - 1'b1;
				return 1'b0;
			end
			wait_count = '0;
			return 1'b1;
		endfunction

		// a zero step would stall the ramp, so it counts as one
		function int unsigned ramp_step();
			return (regs.step_size == 0) ? 1 : 32'(regs.step_size);
		endfunction

		function void advance_sequence(tick_t t);
			logic        far_level;
			int unsigned next_pos;
			far_level = far_is_b ? t.sensor_b : t.sensor_a;
			case (phase)
				PH_CONFIRM1: begin
					if (!t.confirm_button) begin
						wait_count = regs.warn_wait;
						phase = PH_WARN;
					end
				end
				PH_WARN: begin
					if (wait_over()) begin
						if (regs.open_pos >= regs.closed_pos) begin
							servo = regs.open_pos;
							wait_count = 12'(regs.step_ticks);
							phase = PH_CLOSE;
						end else begin
							phase = PH_RAISE;
						end
					end
				end
				PH_CLOSE: begin
					if (wait_over()) begin
						if (32'(servo) >= 32'(regs.closed_pos) + ramp_step()) begin
							servo = servo - 16'(ramp_step());
							wait_count = 12'(regs.step_ticks);
						end else begin
							phase = PH_RAISE;
						end
					end
				end
				PH_RAISE: begin
					if (!t.limit_upper) begin
						motor_up = 1'b0;
						phase = PH_FAR_LOW;
					end else begin
						motor_up = 1'b1;
					end
				end
				PH_FAR_LOW: begin
					if (!far_level) begin
						wait_count = regs.settle;
						phase = PH_SETTLE;
					end
				end
				PH_SETTLE: begin
					if (wait_over())
						phase = PH_FAR_HIGH;
				end
				PH_FAR_HIGH: begin
					if (far_level)
						phase = PH_CONFIRM2;
				end
				PH_CONFIRM2: begin
					if (!t.confirm_button)
						phase = PH_LOWER;
				end
				PH_LOWER: begin
					if (!t.limit_lower) begin
						motor_down = 1'b0;
						if (regs.closed_pos <= regs.open_pos) begin
							servo = regs.closed_pos;
							wait_count = 12'(regs.step_ticks);
							phase = PH_OPEN;
						end else begin
							wait_count = regs.warn_wait;
							phase = PH_END;
						end
					end else begin
						motor_down = 1'b1;
					end
				end
				PH_OPEN: begin
					if (wait_over()) begin
						next_pos = 32'(servo) + ramp_step();
						if (next_pos <= 32'(regs.open_pos)) begin
							servo = next_pos[PosW-1:0];
							wait_count = 12'(regs.step_ticks);
						end else begin
							wait_count = regs.warn_wait;
							phase = PH_END;
						end
					end
				end
				PH_END: begin
					if (wait_over())
						phase = PH_IDLE;
				end
				default: begin
					// sensor A wins when both report a vessel
					if (!t.sensor_a) begin
						far_is_b = 1'b1;
						phase = PH_CONFIRM1;
					end else if (!t.sensor_b) begin
						far_is_b = 1'b0;
						phase = PH_CONFIRM1;
					end
				end
			endcase
		endfunction

		function void note_tick(tick_t t);
			logic    emerg_edge;
			logic    green;
			result_t lights;
			emerg_edge = (t.emergency_pin != last_emerg);
			last_emerg = t.emergency_pin;
			if (frozen) begin
				if (!t.resume_button)
					frozen = 1'b0;
			end else if (emerg_edge) begin
				motor_up   = 1'b0;
				motor_down = 1'b0;
				frozen     = 1'b1;
			end else begin
				advance_sequence(t);
			end
			green = (phase >= PH_FAR_LOW) && (phase <= PH_CONFIRM2);
			lights.motor_raise      = motor_up;
			lights.motor_lower      = motor_down;
			lights.confirm_lamp     = (phase == PH_CONFIRM1) || (phase == PH_CONFIRM2);
			lights.boat_green       = green;
			lights.boat_red         = !green;
			lights.barrier_position = servo;
			lights.barrier_drive    = (phase == PH_CLOSE) || (phase == PH_OPEN);
			lights.warning_blink    = (phase >= PH_WARN) && (phase <= PH_END);
			lights.halted           = frozen;
			pending_outputs.push_back(lights);
		endfunction

		task report(string what);
			errors++;
			if (errors <= 100)
				$display("[%0t] %s", $time, what);
		endtask

		task compare_field(string field, logic [PosW-1:0] got, logic [PosW-1:0] want);
			if (got !== want)
				report($sformatf("result %0d: %s is %0d, expected %0d", checked, field, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending_outputs.size() == 0) begin
				report($sformatf("result %h arrived with no tick outstanding", got));
				return;
			end
			want = pending_outputs.pop_front();
			compare_field("motor_raise", PosW'(got.motor_raise), PosW'(want.motor_raise));
			compare_field("motor_lower", PosW'(got.motor_lower), PosW'(want.motor_lower));
			compare_field("confirm_lamp", PosW'(got.confirm_lamp), PosW'(want.confirm_lamp));
			compare_field("boat_green", PosW'(got.boat_green), PosW'(want.boat_green));
			compare_field("boat_red", PosW'(got.boat_red), PosW'(want.boat_red));
			compare_field("barrier_position", got.barrier_position, want.barrier_position);
			compare_field("barrier_drive", PosW'(got.barrier_drive), PosW'(want.barrier_drive));
			compare_field("warning_blink", PosW'(got.warning_blink), PosW'(want.warning_blink));
			compare_field("halted", PosW'(got.halted), PosW'(want.halted));
			checked++;
		endtask
	endclass

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                tick_valid   = 1'b0;
	logic                tick_stall;
	tick_t               tick         = '1;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                cfg_write    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index    = '0;
	logic [PosW-1:0]     cfg_data     = '0;

	bridge_scoreboard sb;
	int unsigned      burst_left  = 0;
	int unsigned      gap_len     = 0;
	int unsigned      cycle_count = 0;
	int unsigned      quiet_cycles = 0;
	int unsigned      stall_left  = 0;
	int unsigned      stall_mode  = 0;

	// bits: sensor_a sensor_b limit_lower limit_upper confirm resume emergency
	tick_t directed_ticks [25] = '{
		7'b0011110, // both sensors low, A takes priority
		7'b1111110,
		7'b1111010, // confirm
		7'b1111110, 7'b1111110, 7'b1111110, 7'b1111110, // warning, closing ramp
		7'b1111110, // raise with motor on
		7'b1111111, // emergency edge
		7'b1111111,
		7'b1111101, // resume
		7'b1111111, // raise drives the motor again
		7'b1110111, // upper limit reached
		7'b0111111, // near sensor only
		7'b1011111, // far sensor sees the vessel
		7'b1111111,
		7'b1011111, // vessel still at far sensor
		7'b1111111,
		7'b1111011, // second confirm
		7'b1101111, // deck already at lower limit
		7'b1111111, 7'b1111111, 7'b1111111, 7'b1111111,
		7'b1011111  // sensor B starts the next sequence
	};

	drawbridge_sequencer_core dut (
		.clk,
		.arst_n,
		.tick_valid,
		.tick_stall,
		.tick,
		.result_valid,
		.result_stall,
		.result,
		.cfg_write,
		.cfg_index,
		.cfg_data
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// result side stall pattern, switching mode now and then
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 150);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= (cycle_count % 3 == 0);
			default: result_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one tick, hold it until taken, then maybe pause the burst
	task automatic send_tick(input tick_t t);
		tick_valid <= 1'b1;
		tick <= t;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		sb.note_tick(t);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 20);
			gap_len = $urandom_range(1, 6);
			tick_valid <= 1'b0;
			repeat (gap_len) @(posedge clk);
		end
	endtask

	task automatic drain();
		tick_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PipeLatency) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= PosW'(value);
		@(posedge clk);
		sb.write_reg(idx, PosW'(value));
	endtask

	task automatic apply_setting(input int unsigned open_pos, closed_pos, step_sz, step_ticks,
	                             warn_len, settle_len);
		drain();
		put_reg(REG_OPEN_POS, open_pos);
		put_reg(REG_CLOSED_POS, closed_pos);
		put_reg(REG_STEP_SIZE, step_sz);
		put_reg(REG_STEP_TICKS, step_ticks);
		put_reg(REG_WARN_WAIT, warn_len);
		put_reg(REG_SETTLE, settle_len);
		cfg_write <= 1'b0;
	endtask

	// mostly ticks that move the sequence on from the predicted phase, some pure noise
	function automatic tick_t steer_tick();
		tick_t t;
		logic  far_level;
		if ($urandom_range(0, 9) == 0)
			return tick_t'($urandom_range(0, 127));
		t.sensor_a       = ($urandom_range(0, 7) != 0);
		t.sensor_b       = ($urandom_range(0, 7) != 0);
		t.limit_lower    = ($urandom_range(0, 7) != 0);
		t.limit_upper    = ($urandom_range(0, 7) != 0);
		t.confirm_button = ($urandom_range(0, 7) != 0);
		t.resume_button  = ($urandom_range(0, 7) != 0);
		t.emergency_pin  = ($urandom_range(0, 59) == 0) ? !sb.last_emerg : sb.last_emerg;
		case (sb.phase)
			PH_IDLE: begin
				case ($urandom_range(0, 3))
					0: t.sensor_a = 1'b0;
					1: t.sensor_b = 1'b0;
					default: ;
				endcase
			end
			PH_CONFIRM1, PH_CONFIRM2: t.confirm_button = ($urandom_range(0, 2) != 0);
			PH_RAISE: t.limit_upper = ($urandom_range(0, 3) != 0);
			PH_LOWER: t.limit_lower = ($urandom_range(0, 3) != 0);
			PH_FAR_LOW, PH_FAR_HIGH: begin
				far_level = (sb.phase == PH_FAR_LOW) ? ($urandom_range(0, 2) != 0)
				                                     : 1'($urandom_range(0, 1));
				if (sb.far_is_b)
					t.sensor_b = far_level;
				else
					t.sensor_a = far_level;
			end
			default: ;
		endcase
		if (sb.frozen)
			t.resume_button = ($urandom_range(0, 2) != 0);
		return t;
	endfunction

	task automatic run_phase(input int unsigned open_pos, closed_pos, step_sz, step_ticks,
	                         warn_len, settle_len, items);
		apply_setting(open_pos, closed_pos, step_sz, step_ticks, warn_len, settle_len);
		repeat (items)
			send_tick(steer_tick());
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short waits and ramps so the walk covers a full sequence
		apply_setting(40, 20, 10, 1, 1, 1);
		foreach (directed_ticks[i])
			send_tick(directed_ticks[i]);

		run_phase(300, 200, 25, 2, 3, 2, 240);
		run_phase(39999, 0, 1000, 1, 1, 1, 220);
		// open below closed: both ramps empty, waits of zero
		run_phase(500, 600, 1, 3, 0, 0, 180);
		run_phase(1000, 990, 0, 0, 2, 4, 200);
		run_phase(700, 700, 1000, 2, 5, 3, 200);
		// longest waits last, they hold the sequence for thousands of ticks
		run_phase(39999, 39999, 1000, 255, 4095, 4095, 100);

		drain();
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
